// ===== sv/multidim_array_address_store_assert.svh =====
// Assertion macros for the multi-dimensional array store.
`ifndef MULTIDIM_ARRAY_ADDRESS_STORE_ASSERT_SVH
`define MULTIDIM_ARRAY_ADDRESS_STORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define MAS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define MAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mad_pkg.sv =====
// Shared types, constants and codes for the multi-dimensional array store.
package mad_pkg;

  localparam int MAX_DIMS    = 4;
  localparam int STORE_DEPTH = 4096;
  localparam int DATA_WIDTH  = 32;

  localparam int NUM_BOUNDS = 4;
  localparam int NUM_INDEX  = 4;
  localparam int BOUND_W    = 8;
  localparam int IDX_W      = 8;
  localparam int NDIM_W     = 3;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PROD_W = ADDR_W + 1;
  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int TERM_W = PROD_W + IDX_W;
  localparam int OFF_W  = TERM_W + DIM_W;

  localparam logic [PROD_W-1:0] PROD_SAT = PROD_W'(STORE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_0  = 3'd1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SHAPE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [NDIM_W-1:0]                 num_dims;
    logic [MAX_DIMS-1:0][BOUND_W-1:0]  bounds;
    logic [MAX_DIMS-1:0][PROD_W-1:0]   strides;
    logic                              too_large;
    logic                              busy;
  } shape_t;

endpackage

// ===== sv/multidim_array_address_store.sv =====
// Row-major multi-dimensional array store: access sequencer, element RAM, output register.
// Products are registered at the input transfer, the offset add and RAM access run in
// ST_ACC, and ST_DONE loads the output register; the input stalls until that load.
// A configuration write recomputes the strides one dimension per cycle,
// holding the input stalled until the strides are done.
// Reset: synchronous, active low; one dimension of bound 1, output empty, RAM not cleared.
`include "multidim_array_address_store_assert.svh"

module multidim_array_address_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mad_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [mad_pkg::IDX_W-1:0]       in_index_0,
  input  logic [mad_pkg::IDX_W-1:0]       in_index_1,
  input  logic [mad_pkg::IDX_W-1:0]       in_index_2,
  input  logic [mad_pkg::IDX_W-1:0]       in_index_3,
  input  logic [mad_pkg::VAL_W-1:0]       in_write_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mad_pkg::VAL_W-1:0]       out_read_value,
  output logic [mad_pkg::STAT_W-1:0]      out_status
);

  mad_pkg::shape_t shape;
  mad_pkg::state_t state_r, state_nxt;

  logic [mad_pkg::IDX_W-1:0]  in_idx4 [mad_pkg::NUM_INDEX];
  logic [mad_pkg::IDX_W-1:0]  idx     [mad_pkg::MAX_DIMS];
  logic                       in_xfer;
  logic                       oor;

  logic [mad_pkg::TERM_W-1:0]     term_r [mad_pkg::MAX_DIMS];
  logic                           oor_r;
  logic                           big_r;
  logic                           op_r;
  logic [mad_pkg::VAL_W-1:0]      wval_r;
  logic [mad_pkg::STAT_W-1:0]     res_status_r;
  logic                           res_rd_r;

  logic [mad_pkg::OFF_W-1:0]      offset;
  logic [mad_pkg::STAT_W-1:0]     acc_status;
  logic                           ram_we;
  logic                           ram_re;
  logic                           out_load;
  logic [mad_pkg::DATA_WIDTH-1:0] ram_rdata;
  logic [mad_pkg::DATA_WIDTH+mad_pkg::VAL_W-1:0] wval_ext;
  logic [mad_pkg::DATA_WIDTH+mad_pkg::VAL_W-1:0] rdata_ext;

  logic                           out_valid_r;
  logic [mad_pkg::VAL_W-1:0]      out_read_value_r;
  logic [mad_pkg::STAT_W-1:0]     out_status_r;
  logic                           out_err;

  mad_shape u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .shape     (shape)
  );

  assign in_idx4[0] = in_index_0;
  assign in_idx4[1] = in_index_1;
  assign in_idx4[2] = in_index_2;
  assign in_idx4[3] = in_index_3;

  always_comb begin
    for (int d = 0; d < mad_pkg::MAX_DIMS; d++) begin
      idx[d] = (d < mad_pkg::NUM_INDEX) ? in_idx4[d % mad_pkg::NUM_INDEX] : '0;
    end
  end

  always_comb begin
    oor = 1'b0;
    for (int d = 0; d < mad_pkg::MAX_DIMS; d++) begin
      if (d < int'(shape.num_dims) && idx[d] >= shape.bounds[d]) begin
        oor = 1'b1;
      end
    end
  end

  always_comb begin
    offset = '0;
    for (int d = 0; d < mad_pkg::MAX_DIMS; d++) begin
      offset = offset + mad_pkg::OFF_W'(term_r[d]);
    end
  end

  always_comb begin
    if (big_r) begin
      acc_status = mad_pkg::STAT_SHAPE;
    end else if (oor_r) begin
      acc_status = mad_pkg::STAT_RANGE;
    end else if (offset >= mad_pkg::OFF_W'(mad_pkg::STORE_DEPTH)) begin
      acc_status = mad_pkg::STAT_SHAPE;
    end else begin
      acc_status = mad_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mad_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = mad_pkg::ST_ACC;
        end
      end
      mad_pkg::ST_ACC: begin
        state_nxt = mad_pkg::ST_DONE;
      end
      mad_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = mad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mad_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      mad_pkg::ST_IDLE: begin
        in_stall = shape.busy | cfg_we;
      end
      mad_pkg::ST_ACC: begin
        ram_we = (acc_status == mad_pkg::STAT_OK) && (op_r == mad_pkg::OP_WRITE);
        ram_re = (acc_status == mad_pkg::STAT_OK) && (op_r == mad_pkg::OP_READ);
      end
      mad_pkg::ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_xfer  = in_valid && !in_stall;
  assign wval_ext = {mad_pkg::DATA_WIDTH'(0), wval_r};
  assign rdata_ext = {mad_pkg::VAL_W'(0), ram_rdata};

  mad_ram #(
    .WIDTH (mad_pkg::DATA_WIDTH),
    .DEPTH (mad_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (offset[mad_pkg::ADDR_W-1:0]),
    .wdata (wval_ext[mad_pkg::DATA_WIDTH-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mad_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int d = 0; d < mad_pkg::MAX_DIMS; d++) begin
        term_r[d] <= shape.strides[d] * idx[d];
      end
      oor_r  <= oor;
      big_r  <= shape.too_large;
      op_r   <= in_op;
      wval_r <= in_write_value;
    end
    if (state_r == mad_pkg::ST_ACC) begin
      res_status_r <= acc_status;
      res_rd_r     <= (acc_status == mad_pkg::STAT_OK) && (op_r == mad_pkg::OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r     <= res_status_r;
      out_read_value_r <= res_rd_r ? rdata_ext[mad_pkg::VAL_W-1:0] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_err        = out_valid_r && (out_status_r != mad_pkg::STAT_OK);

  `MAS_ASSERT_NEXT(a_xfer_to_acc, in_xfer, state_r == mad_pkg::ST_ACC, "no access stage")
  `MAS_ASSERT_IMPL(a_ram_one_op, ram_we, !ram_re, "RAM read and write in the same cycle")
  `MAS_ASSERT_IMPL(a_busy_stall, shape.busy, in_stall, "input open during strides")
  `MAS_ASSERT_IMPL(a_err_zero, out_err, out_read_value == '0, "failed access returns data")

endmodule

// ===== sv/mad_ram.sv =====
// Generic single-port RAM with registered read.
module mad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/mad_shape.sv =====
// Shape registers and sequential stride derivation, one dimension per cycle.
module mad_shape (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mad_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mad_pkg::shape_t                 shape
);

  logic [mad_pkg::NDIM_W-1:0]                         num_dims_r;
  logic [mad_pkg::MAX_DIMS-1:0][mad_pkg::BOUND_W-1:0] bounds_r;
  logic [mad_pkg::MAX_DIMS-1:0][mad_pkg::PROD_W-1:0]  strides_r;
  logic                                               too_large_r;
  logic                                               start_r;
  logic                                               busy_r;
  logic [mad_pkg::DIM_W-1:0]                          cnt_r;
  logic [mad_pkg::PROD_W-1:0]                         prod_r;
  logic [mad_pkg::PROD_W+mad_pkg::BOUND_W-1:0]        prod_full;
  logic [mad_pkg::PROD_W-1:0]                         prod_sat;
  logic [mad_pkg::NDIM_W-1:0]                         nd_wr;

  assign nd_wr     = cfg_wdata[mad_pkg::NDIM_W-1:0];
  assign prod_full = prod_r * bounds_r[cnt_r];
  assign prod_sat  = (prod_full > (mad_pkg::PROD_W + mad_pkg::BOUND_W)'(mad_pkg::PROD_SAT)) ?
                     mad_pkg::PROD_SAT : prod_full[mad_pkg::PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r  <= mad_pkg::NDIM_W'(1);
      for (int d = 0; d < mad_pkg::MAX_DIMS; d++) begin
        bounds_r[d]  <= mad_pkg::BOUND_W'(1);
        strides_r[d] <= (d == 0) ? mad_pkg::PROD_W'(1) : '0;
      end
      too_large_r <= 1'b0;
      start_r     <= 1'b0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      prod_r      <= mad_pkg::PROD_W'(1);
    end else begin
      start_r <= cfg_we;
      if (cfg_we) begin
        if (cfg_index == mad_pkg::CFG_NUM_DIMS) begin
          if (nd_wr != '0 && int'(nd_wr) <= mad_pkg::MAX_DIMS) begin
            num_dims_r <= nd_wr;
          end
        end
        for (int d = 0; d < mad_pkg::MAX_DIMS; d++) begin
          if (d < mad_pkg::NUM_BOUNDS &&
              cfg_index == mad_pkg::CFG_BOUND_0 + mad_pkg::CFG_IDX_W'(d)) begin
            bounds_r[d] <= cfg_wdata[mad_pkg::BOUND_W-1:0];
          end
        end
      end
      if (start_r) begin
        strides_r <= '0;
        cnt_r     <= mad_pkg::DIM_W'(num_dims_r - mad_pkg::NDIM_W'(1));
        prod_r    <= mad_pkg::PROD_W'(1);
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        strides_r[cnt_r] <= prod_r;
        prod_r           <= prod_sat;
        cnt_r            <= cnt_r - mad_pkg::DIM_W'(1);
        if (cnt_r == '0) begin
          busy_r      <= 1'b0;
          too_large_r <= (prod_sat > mad_pkg::PROD_W'(mad_pkg::STORE_DEPTH));
        end
      end
    end
  end

  always_comb begin
    shape.num_dims  = num_dims_r;
    shape.bounds    = bounds_r;
    shape.strides   = strides_r;
    shape.too_large = too_large_r;
    shape.busy      = start_r | busy_r;
  end

endmodule
